>>> rtl/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// shared widths, codes, command/status types and fixed-point helpers for the
// phong light accumulator
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int MAX_LIGHTS  = 8;
  localparam int LIGHT_IDX_W = $clog2(MAX_LIGHTS);
  localparam int COMP_W      = 21;
  localparam int VEC_W       = 63;
  localparam int LT_W        = 4 * VEC_W;
  localparam int FRAC        = 10;
  localparam int UFRAC       = 14;

  localparam int LCNT_W      = 4;
  localparam int SHIN_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 8;

  localparam int DIFF_W      = COMP_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int ROOT_W      = SQ_W + 2;
  localparam int LEN_W       = DIFF_W;
  localparam int DIVN_W      = COMP_W + UFRAC;
  localparam int DIR_W       = UFRAC + 3;
  localparam int LAM_W       = 29;
  localparam int REF_W       = 25;
  localparam int DOT_W       = 48;
  localparam int POW_W       = 30;
  localparam int S2_W        = 31;
  localparam int ACC_W       = 41;
  localparam int SUM_W       = ACC_W + 2;
  localparam int MA_W        = 42;
  localparam int MB_W        = 32;
  localparam int PROD_W      = MA_W + MB_W;

  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(SQ_W / 2 + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DIVN_W);

  localparam logic [POW_W-1:0] POW_MAX = '1;
  localparam logic [POW_W-1:0] ONE_U   = POW_W'(1) << UFRAC;

  localparam logic signed [PROD_W-1:0] ACC_MAX = (PROD_W'(1) << (ACC_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] REF_MAX = (PROD_W'(1) << (REF_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] CMP_MAX = (PROD_W'(1) << (COMP_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] CMP_MIN = -(PROD_W'(1) << (COMP_W - 1));

  // input opcodes
  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_SHADE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHINE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LCOUNT   = 3'd4;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLR, OP_RD, OP_DIFF, OP_SQ_MUL, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE, OP_AMB, OP_LN_MUL, OP_LN_ACC, OP_LAM,
    OP_DIF_MUL, OP_DIF_ACC, OP_RF_MUL, OP_RF_ACC, OP_IR_MUL, OP_IR_ACC, OP_SD,
    OP_POW_MUL, OP_POW_ACC, OP_S2_MUL, OP_S2_ACC, OP_SP_MUL, OP_SP_ACC,
    OP_FIN_MUL, OP_FIN_ACC, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    FIN_AMB, FIN_DIF, FIN_SPC, FIN_OUT
  } fin_t;

  typedef struct packed {
    op_t                    op;
    fin_t                   fin;
    logic [1:0]             comp;
    logic [LIGHT_IDX_W-1:0] light;
  } cmd_t;

  typedef struct packed {
    logic              lam_pos;
    logic [LCNT_W-1:0] nlights;
    logic [SHIN_W-1:0] shininess;
  } sts_t;

  function automatic logic signed [COMP_W-1:0] comp_of(input logic [VEC_W-1:0] w,
                                                       input logic [1:0] i);
    comp_of = $signed(w[i*COMP_W +: COMP_W]);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W-1:0] v);
    if (v > ACC_MAX) begin
      sat_acc = ACC_W'(ACC_MAX);
    end else if (v < -ACC_MAX) begin
      sat_acc = ACC_W'(-ACC_MAX);
    end else begin
      sat_acc = ACC_W'(v);
    end
  endfunction

  function automatic logic signed [REF_W-1:0] sat_ref(input logic signed [PROD_W-1:0] v);
    if (v > REF_MAX) begin
      sat_ref = REF_W'(REF_MAX);
    end else if (v < -REF_MAX) begin
      sat_ref = REF_W'(-REF_MAX);
    end else begin
      sat_ref = REF_W'(v);
    end
  endfunction

  function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [PROD_W-1:0] v);
    if (v > CMP_MAX) begin
      sat_comp = COMP_W'(CMP_MAX);
    end else if (v < CMP_MIN) begin
      sat_comp = COMP_W'(CMP_MIN);
    end else begin
      sat_comp = COMP_W'(v);
    end
  endfunction

endpackage

>>> rtl/phong_light_accumulator_top.sv
// ----------------------------------------------------------------------------
// phong_light_accumulator_top
// phong shading of one hit point over a table of up to eight point lights
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low. a load (opcode 0)
// writes one light slot in that cycle and leaves busy low, so loads can follow
// back to back. a shade (opcode 1) raises busy and produces one color, shown on
// out_shaded_color for exactly one cycle while out_valid is high; the receiver
// must take it then, there is no hold-off. shade latency is set by the single
// shared multiplier and the bit-serial square root and divider: setup and final
// scaling, plus a pass per light that ends after the lambert term when it is
// not positive and runs on to the specular sum for each lit light (the square
// root takes 23 steps, each of the three direction divides 35 steps, and the
// specular power one multiply and one clamp per exponent step). config writes
// are always ready and should only be issued while busy is low; slots read by
// a shade must have been loaded first.
module phong_light_accumulator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic [2:0]                        in_slot,
  input  logic [pla_pkg::VEC_W-1:0]         in_vec_a,
  input  logic [pla_pkg::VEC_W-1:0]         in_vec_b,
  input  logic [pla_pkg::VEC_W-1:0]         in_vec_c,
  input  logic [pla_pkg::VEC_W-1:0]         in_vec_d,
  // result strobe
  output logic                              out_valid,
  output logic [pla_pkg::VEC_W-1:0]         out_shaded_color,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pla_pkg::VEC_W-1:0]         cfg_data
);

  pla_pkg::cmd_t cmd;
  pla_pkg::sts_t sts;
  logic          in_acc;

  // transaction accepted on start while not busy
  assign in_acc    = start && !busy;
  // registers take a write in any cycle
  assign cfg_ready = 1'b1;
  // result strobe is the controller's emit step
  assign out_valid = (cmd.op == pla_pkg::OP_EMIT);

  pla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  pla_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_acc           (in_acc),
    .in_opcode        (in_opcode),
    .in_slot          (in_slot),
    .in_vec_a         (in_vec_a),
    .in_vec_b         (in_vec_b),
    .in_vec_c         (in_vec_c),
    .in_vec_d         (in_vec_d),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_shaded_color (out_shaded_color)
  );

endmodule

>>> rtl/pla_ctrl.sv
// ----------------------------------------------------------------------------
// pla_ctrl
// sequencer: walks the lights and steps the datapath one operation a cycle
// ----------------------------------------------------------------------------
module pla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  logic            in_opcode,
  input  pla_pkg::sts_t   sts,
  output pla_pkg::cmd_t   cmd,
  output logic            busy
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_CLR, ST_RD, ST_DIFF, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_INIT, ST_SQRT,
    ST_DIV_INIT, ST_DIV, ST_DIV_DONE, ST_AMB, ST_LN_MUL, ST_LN_ACC, ST_LAM,
    ST_DIF_MUL, ST_DIF_ACC, ST_RF_MUL, ST_RF_ACC, ST_IR_MUL, ST_IR_ACC, ST_SD,
    ST_POW_MUL, ST_POW_ACC, ST_S2_MUL, ST_S2_ACC, ST_SP_MUL, ST_SP_ACC, ST_NEXT,
    ST_FIN_MUL, ST_FIN_ACC, ST_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  comp_r, comp_nxt;
  pla_pkg::fin_t               fin_r, fin_nxt;
  logic [pla_pkg::LCNT_W-1:0]  light_r, light_nxt;
  logic [pla_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        last_comp;

  assign last_comp = (comp_r == 2'd2);

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    fin_nxt   = fin_r;
    light_nxt = light_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == pla_pkg::OPC_SHADE)) begin
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        light_nxt = '0;
        comp_nxt  = '0;
        fin_nxt   = pla_pkg::FIN_AMB;
        state_nxt = (sts.nlights == '0) ? ST_FIN_MUL : ST_RD;
      end
      ST_RD:   state_nxt = ST_DIFF;
      ST_DIFF: begin
        comp_nxt  = '0;
        state_nxt = ST_SQ_MUL;
      end
      ST_SQ_MUL: state_nxt = ST_SQ_ACC;
      ST_SQ_ACC: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_SQRT_INIT : ST_SQ_MUL;
      end
      ST_SQRT_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pla_pkg::SQRT_STEPS - 1'b1) begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pla_pkg::DIV_STEPS - 1'b1) begin
          state_nxt = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_AMB : ST_DIV_INIT;
      end
      ST_AMB:    state_nxt = ST_LN_MUL;
      ST_LN_MUL: state_nxt = ST_LN_ACC;
      ST_LN_ACC: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_LAM : ST_LN_MUL;
      end
      ST_LAM:     state_nxt = sts.lam_pos ? ST_DIF_MUL : ST_NEXT;
      ST_DIF_MUL: state_nxt = ST_DIF_ACC;
      ST_DIF_ACC: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_RF_MUL : ST_DIF_MUL;
      end
      ST_RF_MUL: state_nxt = ST_RF_ACC;
      ST_RF_ACC: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_IR_MUL : ST_RF_MUL;
      end
      ST_IR_MUL: state_nxt = ST_IR_ACC;
      ST_IR_ACC: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_SD : ST_IR_MUL;
      end
      ST_SD: begin
        cnt_nxt   = '0;
        state_nxt = (sts.shininess == '0) ? ST_S2_MUL : ST_POW_MUL;
      end
      ST_POW_MUL: state_nxt = ST_POW_ACC;
      ST_POW_ACC: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (cnt_r + 1'b1 == sts.shininess) ? ST_S2_MUL : ST_POW_MUL;
      end
      ST_S2_MUL: state_nxt = ST_S2_ACC;
      ST_S2_ACC: state_nxt = ST_SP_MUL;
      ST_SP_MUL: state_nxt = ST_SP_ACC;
      ST_SP_ACC: begin
        comp_nxt  = last_comp ? 2'd0 : comp_r + 2'd1;
        state_nxt = last_comp ? ST_NEXT : ST_S2_MUL;
      end
      ST_NEXT: begin
        light_nxt = light_r + 1'b1;
        comp_nxt  = '0;
        fin_nxt   = pla_pkg::FIN_AMB;
        state_nxt = (light_r + 1'b1 == sts.nlights) ? ST_FIN_MUL : ST_RD;
      end
      ST_FIN_MUL: state_nxt = ST_FIN_ACC;
      ST_FIN_ACC: begin
        state_nxt = ST_FIN_MUL;
        case (fin_r)
          pla_pkg::FIN_AMB: fin_nxt = pla_pkg::FIN_DIF;
          pla_pkg::FIN_DIF: fin_nxt = pla_pkg::FIN_SPC;
          pla_pkg::FIN_SPC: fin_nxt = pla_pkg::FIN_OUT;
          default: begin
            fin_nxt  = pla_pkg::FIN_AMB;
            comp_nxt = last_comp ? 2'd0 : comp_r + 2'd1;
            if (last_comp) begin
              state_nxt = ST_EMIT;
            end
          end
        endcase
      end
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      comp_r  <= '0;
      fin_r   <= pla_pkg::FIN_AMB;
      light_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      fin_r   <= fin_nxt;
      light_r <= light_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    cmd.comp  = comp_r;
    cmd.fin   = fin_r;
    cmd.light = light_r[pla_pkg::LIGHT_IDX_W-1:0];
    case (state_r)
      ST_CLR:       cmd.op = pla_pkg::OP_CLR;
      ST_RD:        cmd.op = pla_pkg::OP_RD;
      ST_DIFF:      cmd.op = pla_pkg::OP_DIFF;
      ST_SQ_MUL:    cmd.op = pla_pkg::OP_SQ_MUL;
      ST_SQ_ACC:    cmd.op = pla_pkg::OP_SQ_ACC;
      ST_SQRT_INIT: cmd.op = pla_pkg::OP_SQRT_INIT;
      ST_SQRT:      cmd.op = pla_pkg::OP_SQRT_STEP;
      ST_DIV_INIT:  cmd.op = pla_pkg::OP_DIV_INIT;
      ST_DIV:       cmd.op = pla_pkg::OP_DIV_STEP;
      ST_DIV_DONE:  cmd.op = pla_pkg::OP_DIV_DONE;
      ST_AMB:       cmd.op = pla_pkg::OP_AMB;
      ST_LN_MUL:    cmd.op = pla_pkg::OP_LN_MUL;
      ST_LN_ACC:    cmd.op = pla_pkg::OP_LN_ACC;
      ST_LAM:       cmd.op = pla_pkg::OP_LAM;
      ST_DIF_MUL:   cmd.op = pla_pkg::OP_DIF_MUL;
      ST_DIF_ACC:   cmd.op = pla_pkg::OP_DIF_ACC;
      ST_RF_MUL:    cmd.op = pla_pkg::OP_RF_MUL;
      ST_RF_ACC:    cmd.op = pla_pkg::OP_RF_ACC;
      ST_IR_MUL:    cmd.op = pla_pkg::OP_IR_MUL;
      ST_IR_ACC:    cmd.op = pla_pkg::OP_IR_ACC;
      ST_SD:        cmd.op = pla_pkg::OP_SD;
      ST_POW_MUL:   cmd.op = pla_pkg::OP_POW_MUL;
      ST_POW_ACC:   cmd.op = pla_pkg::OP_POW_ACC;
      ST_S2_MUL:    cmd.op = pla_pkg::OP_S2_MUL;
      ST_S2_ACC:    cmd.op = pla_pkg::OP_S2_ACC;
      ST_SP_MUL:    cmd.op = pla_pkg::OP_SP_MUL;
      ST_SP_ACC:    cmd.op = pla_pkg::OP_SP_ACC;
      ST_FIN_MUL:   cmd.op = pla_pkg::OP_FIN_MUL;
      ST_FIN_ACC:   cmd.op = pla_pkg::OP_FIN_ACC;
      ST_EMIT:      cmd.op = pla_pkg::OP_EMIT;
      default:      cmd.op = pla_pkg::OP_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/pla_dp.sv
// ----------------------------------------------------------------------------
// pla_dp
// datapath: light table, config registers, shared multiplier, iterative
// square root and divider, per-channel accumulators
// ----------------------------------------------------------------------------
module pla_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_acc,
  input  logic                                 in_opcode,
  input  logic [pla_pkg::LIGHT_IDX_W-1:0]      in_slot,
  input  logic [pla_pkg::VEC_W-1:0]            in_vec_a,
  input  logic [pla_pkg::VEC_W-1:0]            in_vec_b,
  input  logic [pla_pkg::VEC_W-1:0]            in_vec_c,
  input  logic [pla_pkg::VEC_W-1:0]            in_vec_d,
  input  logic                                 cfg_we,
  input  logic [pla_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pla_pkg::VEC_W-1:0]            cfg_data,
  input  pla_pkg::cmd_t                        cmd,
  output pla_pkg::sts_t                        sts,
  output logic [pla_pkg::VEC_W-1:0]            out_shaded_color
);

  localparam logic signed [pla_pkg::DOT_W-1:0]  SD_MAX = pla_pkg::DOT_W'(pla_pkg::POW_MAX);
  localparam logic signed [pla_pkg::PROD_W-1:0] P_MAX  = pla_pkg::PROD_W'(pla_pkg::POW_MAX);

  // config
  logic [pla_pkg::VEC_W-1:0]  ka_r, kd_r, ks_r;
  logic [pla_pkg::SHIN_W-1:0] shin_r;
  logic [pla_pkg::LCNT_W-1:0] lcnt_r;

  // light table and operands
  logic [pla_pkg::LT_W-1:0]   lt_mem [pla_pkg::MAX_LIGHTS];
  logic [pla_pkg::LT_W-1:0]   lt_r;
  logic [pla_pkg::VEC_W-1:0]  hit_r, nrm_r, inc_r, col_r;

  logic signed [pla_pkg::DIFF_W-1:0] d_r   [3];
  logic signed [pla_pkg::DIR_W-1:0]  l_r   [3];
  logic signed [pla_pkg::REF_W-1:0]  r_r   [3];
  logic signed [pla_pkg::ACC_W-1:0]  amb_r [3];
  logic signed [pla_pkg::ACC_W-1:0]  dif_r [3];
  logic signed [pla_pkg::ACC_W-1:0]  spc_r [3];
  logic signed [pla_pkg::COMP_W-1:0] out_r [3];

  logic [pla_pkg::SQ_W-1:0]          sq_r, sx_r;
  logic [pla_pkg::ROOT_W-1:0]        sr_r, sb_r;
  logic [pla_pkg::DIVN_W-1:0]        dq_r;
  logic [pla_pkg::LEN_W-1:0]         rem_r;
  logic                              neg_r;
  logic signed [pla_pkg::LAM_W-1:0]  lam_r;
  logic signed [pla_pkg::DOT_W-1:0]  dot_r;
  logic [pla_pkg::POW_W-1:0]         sd_r, p_r;
  logic [pla_pkg::S2_W-1:0]          s2_r;
  logic signed [pla_pkg::SUM_W-1:0]  t_r;
  logic signed [pla_pkg::PROD_W-1:0] prod_r;

  // combinational
  logic signed [pla_pkg::COMP_W-1:0] pos_c [3];
  logic signed [pla_pkg::COMP_W-1:0] hit_c [3];
  logic signed [pla_pkg::COMP_W-1:0] la_c, ld_c, ls_c, nrm_c, inc_c, col_c, ka_c, kd_c, ks_c;
  logic signed [pla_pkg::MA_W-1:0]   ma;
  logic signed [pla_pkg::MB_W-1:0]   mb;
  logic [pla_pkg::ROOT_W-1:0]        root_try;
  logic [pla_pkg::LEN_W-1:0]         len;
  logic [pla_pkg::LEN_W:0]           div_try;
  logic [pla_pkg::DIFF_W-1:0]        d_abs;
  logic signed [pla_pkg::DOT_W-1:0]  dot_sh;
  logic signed [pla_pkg::PROD_W-1:0] prod_s10, prod_s14, pow_sh;
  logic [1:0]                        ci;

  assign ci  = cmd.comp;
  assign len = sr_r[pla_pkg::LEN_W-1:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pos_c[j] = pla_pkg::comp_of(lt_r[pla_pkg::VEC_W-1:0], 2'(j));
      hit_c[j] = pla_pkg::comp_of(hit_r, 2'(j));
    end
    la_c  = pla_pkg::comp_of(lt_r[2*pla_pkg::VEC_W-1:pla_pkg::VEC_W], ci);
    ld_c  = pla_pkg::comp_of(lt_r[3*pla_pkg::VEC_W-1:2*pla_pkg::VEC_W], ci);
    ls_c  = pla_pkg::comp_of(lt_r[4*pla_pkg::VEC_W-1:3*pla_pkg::VEC_W], ci);
    nrm_c = pla_pkg::comp_of(nrm_r, ci);
    inc_c = pla_pkg::comp_of(inc_r, ci);
    col_c = pla_pkg::comp_of(col_r, ci);
    ka_c  = pla_pkg::comp_of(ka_r, ci);
    kd_c  = pla_pkg::comp_of(kd_r, ci);
    ks_c  = pla_pkg::comp_of(ks_r, ci);
  end

  assign root_try = sr_r + sb_r;
  assign div_try  = {rem_r, dq_r[pla_pkg::DIVN_W-1]};
  assign d_abs    = d_r[ci][pla_pkg::DIFF_W-1] ? pla_pkg::DIFF_W'(-d_r[ci])
                                               : pla_pkg::DIFF_W'(d_r[ci]);
  assign dot_sh   = dot_r >>> pla_pkg::FRAC;
  assign prod_s10 = prod_r >>> pla_pkg::FRAC;
  assign prod_s14 = prod_r >>> pla_pkg::UFRAC;
  assign pow_sh   = prod_s14;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      pla_pkg::OP_SQ_MUL: begin
        ma = pla_pkg::MA_W'(d_r[ci]);
        mb = pla_pkg::MB_W'(d_r[ci]);
      end
      pla_pkg::OP_LN_MUL: begin
        ma = pla_pkg::MA_W'(l_r[ci]);
        mb = pla_pkg::MB_W'(nrm_c);
      end
      pla_pkg::OP_DIF_MUL: begin
        ma = pla_pkg::MA_W'(ld_c);
        mb = pla_pkg::MB_W'(lam_r);
      end
      pla_pkg::OP_RF_MUL: begin
        ma = pla_pkg::MA_W'(nrm_c);
        mb = pla_pkg::MB_W'(lam_r);
      end
      pla_pkg::OP_IR_MUL: begin
        ma = pla_pkg::MA_W'(inc_c);
        mb = pla_pkg::MB_W'(r_r[ci]);
      end
      pla_pkg::OP_POW_MUL: begin
        ma = pla_pkg::MA_W'(p_r);
        mb = pla_pkg::MB_W'(sd_r);
      end
      pla_pkg::OP_S2_MUL: begin
        ma = pla_pkg::MA_W'(ls_c);
        mb = pla_pkg::MB_W'(ls_c);
      end
      pla_pkg::OP_SP_MUL: begin
        ma = pla_pkg::MA_W'(s2_r);
        mb = pla_pkg::MB_W'(p_r);
      end
      pla_pkg::OP_FIN_MUL: begin
        case (cmd.fin)
          pla_pkg::FIN_AMB: begin
            ma = pla_pkg::MA_W'(amb_r[ci]);
            mb = pla_pkg::MB_W'(ka_c);
          end
          pla_pkg::FIN_DIF: begin
            ma = pla_pkg::MA_W'(dif_r[ci]);
            mb = pla_pkg::MB_W'(kd_c);
          end
          pla_pkg::FIN_SPC: begin
            ma = pla_pkg::MA_W'(spc_r[ci]);
            mb = pla_pkg::MB_W'(ks_c);
          end
          default: begin
            ma = pla_pkg::MA_W'(t_r);
            mb = pla_pkg::MB_W'(col_c);
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ka_r   <= '0;
      kd_r   <= '0;
      ks_r   <= '0;
      shin_r <= pla_pkg::SHIN_W'(20);
      lcnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pla_pkg::CFG_AMBIENT:  ka_r   <= cfg_data;
        pla_pkg::CFG_DIFFUSE:  kd_r   <= cfg_data;
        pla_pkg::CFG_SPECULAR: ks_r   <= cfg_data;
        pla_pkg::CFG_SHINE:    shin_r <= cfg_data[pla_pkg::SHIN_W-1:0];
        pla_pkg::CFG_LCOUNT:   lcnt_r <= cfg_data[pla_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // light table
  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == pla_pkg::OPC_LOAD)) begin
      lt_mem[in_slot] <= {in_vec_d, in_vec_c, in_vec_b, in_vec_a};
    end
    if (cmd.op == pla_pkg::OP_RD) begin
      lt_r <= lt_mem[cmd.light];
    end
  end

  // shade operands
  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == pla_pkg::OPC_SHADE)) begin
      hit_r <= in_vec_a;
      nrm_r <= in_vec_b;
      inc_r <= in_vec_c;
      col_r <= in_vec_d;
    end
  end

  // arithmetic sequence
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (cmd.op)
      pla_pkg::OP_CLR: begin
        for (int j = 0; j < 3; j++) begin
          amb_r[j] <= '0;
          dif_r[j] <= '0;
          spc_r[j] <= '0;
        end
      end
      pla_pkg::OP_DIFF: begin
        for (int j = 0; j < 3; j++) begin
          d_r[j] <= pla_pkg::DIFF_W'(pos_c[j]) - pla_pkg::DIFF_W'(hit_c[j]);
        end
        sq_r <= '0;
      end
      pla_pkg::OP_SQ_ACC: sq_r <= sq_r + prod_r[pla_pkg::SQ_W-1:0];
      pla_pkg::OP_SQRT_INIT: begin
        sx_r <= sq_r;
        sr_r <= '0;
        sb_r <= pla_pkg::ROOT_W'(1) << pla_pkg::SQ_W;
      end
      pla_pkg::OP_SQRT_STEP: begin
        if (pla_pkg::ROOT_W'(sx_r) >= root_try) begin
          sx_r <= pla_pkg::SQ_W'(pla_pkg::ROOT_W'(sx_r) - root_try);
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      pla_pkg::OP_DIV_INIT: begin
        dq_r  <= {d_abs[pla_pkg::COMP_W-1:0], pla_pkg::UFRAC'(0)};
        rem_r <= '0;
        neg_r <= d_r[ci][pla_pkg::DIFF_W-1];
      end
      pla_pkg::OP_DIV_STEP: begin
        if (div_try >= {1'b0, len}) begin
          rem_r <= pla_pkg::LEN_W'(div_try - {1'b0, len});
          dq_r  <= {dq_r[pla_pkg::DIVN_W-2:0], 1'b1};
        end else begin
          rem_r <= div_try[pla_pkg::LEN_W-1:0];
          dq_r  <= {dq_r[pla_pkg::DIVN_W-2:0], 1'b0};
        end
      end
      pla_pkg::OP_DIV_DONE: begin
        // light on the hit point gives a zero direction
        if (len == '0) begin
          l_r[ci] <= '0;
        end else if (neg_r) begin
          l_r[ci] <= -$signed(dq_r[pla_pkg::DIR_W-1:0]);
        end else begin
          l_r[ci] <= $signed(dq_r[pla_pkg::DIR_W-1:0]);
        end
      end
      pla_pkg::OP_AMB: begin
        for (int j = 0; j < 3; j++) begin
          amb_r[j] <= pla_pkg::sat_acc(pla_pkg::PROD_W'(amb_r[j]) + pla_pkg::PROD_W'(
                      pla_pkg::comp_of(lt_r[2*pla_pkg::VEC_W-1:pla_pkg::VEC_W], 2'(j))));
        end
        dot_r <= '0;
      end
      pla_pkg::OP_LN_ACC, pla_pkg::OP_IR_ACC: dot_r <= dot_r + prod_r[pla_pkg::DOT_W-1:0];
      pla_pkg::OP_LAM: begin
        lam_r <= pla_pkg::LAM_W'(dot_sh);
        dot_r <= '0;
      end
      pla_pkg::OP_DIF_ACC: begin
        dif_r[ci] <= pla_pkg::sat_acc(pla_pkg::PROD_W'(dif_r[ci]) + prod_s14);
      end
      pla_pkg::OP_RF_ACC: begin
        r_r[ci] <= pla_pkg::sat_ref(pla_pkg::PROD_W'(l_r[ci]) - (prod_r >>> (pla_pkg::FRAC - 1)));
      end
      pla_pkg::OP_SD: begin
        if (dot_sh < 0) begin
          sd_r <= '0;
        end else if (dot_sh > SD_MAX) begin
          sd_r <= pla_pkg::POW_MAX;
        end else begin
          sd_r <= dot_sh[pla_pkg::POW_W-1:0];
        end
        p_r <= pla_pkg::ONE_U;
      end
      pla_pkg::OP_POW_ACC: begin
        p_r <= (pow_sh > P_MAX) ? pla_pkg::POW_MAX : pow_sh[pla_pkg::POW_W-1:0];
      end
      pla_pkg::OP_S2_ACC: s2_r <= prod_s10[pla_pkg::S2_W-1:0];
      pla_pkg::OP_SP_ACC: begin
        spc_r[ci] <= pla_pkg::sat_acc(pla_pkg::PROD_W'(spc_r[ci])
                     + pla_pkg::PROD_W'(pla_pkg::sat_acc(prod_s14)));
      end
      pla_pkg::OP_FIN_ACC: begin
        case (cmd.fin)
          pla_pkg::FIN_AMB: t_r <= pla_pkg::SUM_W'(pla_pkg::sat_acc(prod_s10));
          pla_pkg::FIN_DIF: t_r <= t_r + pla_pkg::SUM_W'(pla_pkg::sat_acc(prod_s10));
          pla_pkg::FIN_SPC: begin
            t_r <= pla_pkg::SUM_W'(pla_pkg::sat_acc(pla_pkg::PROD_W'(t_r)
                   + pla_pkg::PROD_W'(pla_pkg::sat_acc(prod_s10))));
          end
          default: out_r[ci] <= pla_pkg::sat_comp(prod_s10);
        endcase
      end
      default: ;
    endcase
  end

  assign sts.lam_pos   = !dot_r[pla_pkg::DOT_W-1] && (|dot_r[pla_pkg::DOT_W-2:pla_pkg::FRAC]);
  assign sts.nlights   = (lcnt_r > pla_pkg::LCNT_W'(pla_pkg::MAX_LIGHTS))
                         ? pla_pkg::LCNT_W'(pla_pkg::MAX_LIGHTS) : lcnt_r;
  assign sts.shininess = shin_r;

  assign out_shaded_color = {out_r[2], out_r[1], out_r[0]};

endmodule
